FILE: design/sle_pkg.sv
// sle_pkg: shared constants and types for the sorted list engine
// depends on nothing; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [OCC_W-1:0]          occ_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/sle_if.sv
// sle_in_if / sle_out_if: valid/ready channels for requests and results
// depends on sle_pkg
`timescale 1ns / 1ps
`default_nettype none
interface sle_in_if;
  import sle_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  value_t value;
  modport source (output valid, input ready, output cmd, output value);
  modport sink   (input valid, output ready, input cmd, input value);
endinterface

interface sle_out_if;
  import sle_pkg::*;
  logic valid;
  logic ready;
  logic success;
  pos_t position;
  occ_t occupancy;
  modport source (output valid, input ready, output success, output position,
                  output occupancy);
  modport sink   (input valid, output ready, input success, input position,
                  input occupancy);
endinterface
`default_nettype wire

FILE: design/sle_cell.sv
// sle_cell: one list slot; compares its entry with the key and shifts
// to or from its neighbors; depends on sle_pkg
`timescale 1ns / 1ps
`default_nettype none
module sle_cell (
  input  wire                  clk,
  input  sle_pkg::value_t      key_i,
  input  sle_pkg::cell_ctrl_t  ctrl_i,
  input  wire                  occ_i,
  input  wire                  left_lt_i,
  input  sle_pkg::value_t      left_val_i,
  input  sle_pkg::value_t      right_val_i,
  output logic                 lt_o,
  output logic                 eq_o,
  output logic                 first_o,
  output sle_pkg::value_t      val_o
);
  import sle_pkg::*;

  value_t entry_r;
  value_t entry_nxt;

  assign lt_o    = occ_i && (entry_r < key_i);
  assign eq_o    = occ_i && (entry_r == key_i);
  assign first_o = left_lt_i && !lt_o;
  assign val_o   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.ins && !lt_o) begin
      entry_nxt = first_o ? key_i : left_val_i;
    end else if (ctrl_i.rem && !lt_o) begin
      entry_nxt = right_val_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

FILE: design/sorted_list_engine_core.sv
// sorted_list_engine_core: ascending list of signed values in a row of cells
// depends on sle_pkg, sle_if (sle_in_if, sle_out_if) and sle_cell
// result is registered, out in the next cycle; one request per cycle if no stall
// all cells compare in parallel, at most one shift of the row per request
// result register frees when out ready is high, so requests keep flowing
// sync active-low reset empties the list and drops any pending result
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_engine_core (
  input wire      clk,
  input wire      rst_n,
  sle_in_if.sink  in_if,
  sle_out_if.source out_if
);
  import sle_pkg::*;

  cnt_t       count_r;
  cnt_t       count_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       success_r;
  logic       success_nxt;
  pos_t       position_r;
  pos_t       position_nxt;
  logic       accept;
  logic       full;
  logic       hit;
  idx_t       pos;
  cell_ctrl_t ctrl;

  logic   [CAPACITY-1:0] occ;
  logic   [CAPACITY-1:0] lt;
  logic   [CAPACITY-1:0] eq;
  logic   [CAPACITY-1:0] first;
  logic   [CAPACITY:0]   lt_chain;
  value_t                vals [CAPACITY];

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (count_r == cnt_t'(CAPACITY));
  assign lt_chain[0] = 1'b1;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      value_t left_v;
      value_t right_v;
      assign occ[g]        = (cnt_t'(g) < count_r);
      assign lt_chain[g+1] = lt[g];
      if (g == 0) begin : g_head
        assign left_v = in_if.value;
      end else begin : g_mid_l
        assign left_v = vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_v = vals[g];
      end else begin : g_mid_r
        assign right_v = vals[g+1];
      end
      sle_cell u_cell (
        .clk         (clk),
        .key_i       (in_if.value),
        .ctrl_i      (ctrl),
        .occ_i       (occ[g]),
        .left_lt_i   (lt_chain[g]),
        .left_val_i  (left_v),
        .right_val_i (right_v),
        .lt_o        (lt[g]),
        .eq_o        (eq[g]),
        .first_o     (first[g]),
        .val_o       (vals[g])
      );
    end
  endgenerate

  // boundary has at most one bit set since the less-than flags form a thermometer
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | idx_t'(i);
      end
    end
  end

  assign hit = |(first & eq);

  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    success_nxt  = 1'b0;
    count_nxt    = count_r;
    case (in_if.cmd)
      CMD_INSERT: begin
        success_nxt = !full;
        ctrl.ins    = accept && !full;
        if (!full) begin
          count_nxt = count_r + cnt_t'(1);
        end
      end
      CMD_SEARCH: begin
        success_nxt = hit;
      end
      CMD_REMOVE: begin
        success_nxt = hit;
        ctrl.rem    = accept && hit;
        if (hit) begin
          count_nxt = count_r - cnt_t'(1);
        end
      end
      default: begin
        success_nxt = 1'b0;
      end
    endcase
    position_nxt = success_nxt ? pos_t'(pos) : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      success_r  <= success_nxt;
      position_r <= position_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.success   = success_r;
  assign out_if.position  = position_r;
  assign out_if.occupancy = occ_t'(count_r);

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for sorted_list_engine_core, with a directed
// opening, then random insert/search/remove/unused phases under random idling
// depends on sle_pkg, sle_if (sle_in_if, sle_out_if) and the core it drives
`timescale 1ns / 1ps
module testbench;
  import sle_pkg::*;

  localparam cmd_t        CMD_UNUSED   = 2'd3;
  localparam value_t      VAL_MAX      = 32'sh7fff_ffff;
  localparam value_t      VAL_MIN      = 32'sh8000_0000;
  localparam int          RANDOM_ITEMS = 1625;
  localparam int          IDLE_LIMIT   = 500;
  localparam int          DRAIN_CYCLES = 4;

  typedef struct {
    cmd_t        cmd;
    value_t      value;
    int unsigned gap;
    bit          drain;
  } request_t;

  typedef struct {
    cmd_t   cmd;
    value_t value;
    logic   success;
    pos_t   position;
    occ_t   occupancy;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sle_in_if  in_if ();
  sle_out_if out_if ();

  sorted_list_engine_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the list contents
  value_t       list_vals [CAPACITY];
  int           list_len;
  request_t     pending_requests [$];
  list_result_t expected_results [$];

  int n_pred, n_seen, n_errors;
  int n_ins_ok, n_ins_full, n_hits, n_misses, n_unused, peak_len;

  request_t    drv_req;
  bit          drv_busy;
  int unsigned drv_wait;
  int unsigned hold_left;
  bit          steady_sink;
  int          idle_cycles;

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic predict_list_op(input cmd_t op, input value_t v);
    list_result_t r;
    int           at;
    int           i;
    r.cmd      = op;
    r.value    = v;
    r.success  = 1'b0;
    r.position = '0;
    at         = 0;
    case (op)
      CMD_INSERT: begin
        if (list_len < CAPACITY) begin
          while (at < list_len && list_vals[at] < v) at++;
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = v;
          list_len++;
          r.success  = 1'b1;
          r.position = pos_t'(at);
          n_ins_ok++;
        end else begin
          n_ins_full++;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        while (at < list_len && list_vals[at] != v) at++;
        if (at < list_len) begin
          if (op == CMD_REMOVE) begin
            for (i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
            list_len--;
          end
          r.success  = 1'b1;
          r.position = pos_t'(at);
          n_hits++;
        end else begin
          n_misses++;
        end
      end
      default: n_unused++;
    endcase
    r.occupancy = occ_t'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    expected_results.push_back(r);
  endtask

  task automatic add_request(input cmd_t op, input value_t v, input int unsigned gap,
                             input bit drain);
    request_t q;
    q.cmd   = op;
    q.value = v;
    q.gap   = gap;
    q.drain = drain;
    pending_requests.push_back(q);
  endtask

  function automatic value_t pick_value(input bit narrow);
    case ($urandom_range(0, 11))
      0, 1:    return value_t'($urandom);
      2:       return VAL_MAX - value_t'($urandom_range(0, 2));
      3:       return VAL_MIN + value_t'($urandom_range(0, 2));
      default: return narrow ? value_t'($urandom_range(0, 6)) - 3
                             : value_t'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic cmd_t pick_cmd(input int kind);
    int w;
    int ins_w;
    int srch_w;
    w = $urandom_range(0, 99);
    case (kind)
      0:       begin ins_w = 65; srch_w = 80; end
      1:       begin ins_w = 20; srch_w = 40; end
      default: begin ins_w = 35; srch_w = 65; end
    endcase
    if (w < ins_w)  return CMD_INSERT;
    if (w < srch_w) return CMD_SEARCH;
    if (w < 97)     return CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  // driver: presents queued requests, predicts each one on acceptance
  always @(posedge clk) begin
    bit take_in;
    bit take_out;
    bit show;
    int in_flight;
    take_in  = in_if.valid && in_if.ready;
    take_out = out_if.valid && out_if.ready;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (take_in) begin
        predict_list_op(in_if.cmd, in_if.value);
        n_pred <= n_pred + 1;
        drv_busy = 1'b0;
      end
      in_flight = n_pred - n_seen + int'(take_in) - int'(take_out);
      if (!drv_busy && pending_requests.size() != 0) begin
        drv_req  = pending_requests.pop_front();
        drv_busy = 1'b1;
        drv_wait = drv_req.gap;
      end
      show = 1'b0;
      if (drv_busy) begin
        if (drv_wait != 0) drv_wait--;
        else if (!drv_req.drain || in_flight == 0) show = 1'b1;
      end
      in_if.valid <= show;
      if (show) begin
        in_if.cmd   <= drv_req.cmd;
        in_if.value <= drv_req.value;
      end
    end
  end

  // monitor: random ready stalls, compares each result with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_seen <= n_seen + 1;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result success %0b position %0d occupancy %0d",
                                  out_if.success, out_if.position, out_if.occupancy));
        end else begin
          want = expected_results.pop_front();
          if (out_if.success !== want.success || out_if.position !== want.position ||
              out_if.occupancy !== want.occupancy)
            note_mismatch($sformatf(
              "cmd %0d value %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
              want.cmd, want.value, want.success, want.position, want.occupancy,
              out_if.success, out_if.position, out_if.occupancy));
        end
        hold_left = steady_sink ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) steady_sink = !steady_sink;
      end
      out_if.ready <= (hold_left == 0);
      if (hold_left != 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("sorted_list_engine_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int          kind;
    int          span;
    int          made;
    int          i;
    bit          burst;
    bit          narrow;
    cmd_t        op;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_SEARCH;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    rst_n        = 1'b0;
    list_len     = 0;

    // empty list, unused command, extremes and duplicates
    add_request(CMD_SEARCH, 0, 0, 1'b0);
    add_request(CMD_REMOVE, 0, 1, 1'b0);
    add_request(CMD_UNUSED, -1, 0, 1'b0);
    add_request(CMD_INSERT, VAL_MAX, 0, 1'b0);
    add_request(CMD_INSERT, VAL_MIN, 2, 1'b0);
    add_request(CMD_INSERT, 0, 0, 1'b0);
    add_request(CMD_INSERT, 0, 0, 1'b0);
    add_request(CMD_INSERT, -1, 3, 1'b0);
    add_request(CMD_SEARCH, 0, 0, 1'b0);
    add_request(CMD_SEARCH, 5, 0, 1'b0);
    add_request(CMD_REMOVE, VAL_MIN, 1, 1'b0);
    // fill to capacity, then overflow and remove the top entry
    for (i = 0; i < CAPACITY - 4; i++)
      add_request(CMD_INSERT, value_t'(i * 7 - 40), $urandom_range(0, 2), 1'b0);
    add_request(CMD_INSERT, 3, 0, 1'b0);
    add_request(CMD_REMOVE, VAL_MAX, 0, 1'b0);
    add_request(CMD_UNUSED, VAL_MAX, 0, 1'b0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind   = $urandom_range(0, 3);
      span   = $urandom_range(20, 80);
      burst  = ($urandom_range(0, 3) == 0);
      narrow = $urandom_range(0, 1);
      for (i = 0; i < span; i++) begin
        op = pick_cmd(kind);
        add_request(op, pick_value(narrow), burst ? 0 : $urandom_range(0, 7),
                    i == 0 && (made == 0 || $urandom_range(0, 2) == 0));
      end
      made += span;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_requests.size() != 0 || drv_busy || n_pred != n_seen);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("ran %0d requests: %0d inserts placed, %0d dropped on a full list",
             n_pred, n_ins_ok, n_ins_full);
    $display("search/remove hits %0d, misses %0d, unused commands %0d, peak occupancy %0d",
             n_hits, n_misses, n_unused, peak_len);
    if (n_errors == 0) begin
      $display("sorted_list_engine_core test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("sorted_list_engine_core test failed");
    end
    $finish;
  end

endmodule
